// ===== sv/olist_pkg.sv =====
// Shared types and constants for the ordered list block.
`timescale 1ns / 1ps

package olist_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_WALK   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEL_SCAN,
        S_WALK,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;
        logic    clr_value;
        logic    set_status;
        t_status status;
        logic    wr_insert;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    rd_start;
        logic    advance;
        logic    set_found;
        logic    out_walk;
        logic    out_resp;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       cnt_zero;
        logic       cnt_full;
        logic       idx_last;
        logic       match;
        logic       found;
        logic       out_free;
    } t_stat;

endpackage

// ===== sv/olist_dp.sv =====
// Datapath: entry store, count, scan index, request and result registers.
`timescale 1ns / 1ps

module olist_dp #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  olist_pkg::t_cmd                    i_cmd,
    output olist_pkg::t_stat                   o_stat,
    input  logic [1:0]                         i_action,
    input  logic [olist_pkg::VALUE_W-1:0]      i_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [1:0]                         o_out_status,
    output logic [olist_pkg::VALUE_W-1:0]      o_out_item,
    output logic                               o_out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int VW = olist_pkg::VALUE_W;

    logic [VW-1:0]      r_mem [CAPACITY];
    logic [VW-1:0]      r_rdata;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      n_idx;
    logic [CW-1:0]      r_count;
    logic [1:0]         r_action;
    logic [VW-1:0]      r_value;
    olist_pkg::t_status r_status;
    logic               r_found;
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic [VW-1:0]      r_out_item;
    logic               r_out_last;

    logic [AW-1:0]      wr_addr;
    logic [VW-1:0]      wr_data;
    logic               wr_en;
    logic               idx_last;

    assign idx_last = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        if (i_cmd.rd_start) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign wr_en   = i_cmd.wr_insert | i_cmd.wr_shift;
    assign wr_addr = i_cmd.wr_shift ? (r_idx - AW'(1)) : r_count[AW-1:0];
    assign wr_data = i_cmd.wr_shift ? r_rdata : r_value;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_req) begin
            r_action <= i_action;
            r_value  <= i_value;
        end else if (i_cmd.clr_value) begin
            r_value <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.rd_start) begin
                r_found <= 1'b0;
            end else if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_walk | i_cmd.out_resp) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_walk) begin
            r_out_status <= olist_pkg::ST_OK;
            r_out_item   <= r_rdata;
            r_out_last   <= idx_last;
        end else if (i_cmd.out_resp) begin
            r_out_status <= r_status;
            r_out_item   <= r_value;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stat.action   = r_action;
    assign o_stat.cnt_zero = (r_count == '0);
    assign o_stat.cnt_full = (r_count == CW'(CAPACITY));
    assign o_stat.idx_last = idx_last;
    assign o_stat.match    = (r_rdata == r_value);
    assign o_stat.found    = r_found;
    assign o_stat.out_free = ~r_out_valid | i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_item   = r_out_item;
    assign o_out_last   = r_out_last;

endmodule

// ===== sv/olist_ctrl.sv =====
// Controller: sequences insert, delete scan with compaction, and walk.
`timescale 1ns / 1ps

module olist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  olist_pkg::t_stat i_stat,
    output olist_pkg::t_cmd  o_cmd
);

    olist_pkg::t_state r_state;
    olist_pkg::t_state n_state;
    logic              hit;

    assign hit = i_stat.found | i_stat.match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= olist_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            olist_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = olist_pkg::S_DECODE;
                end
            end
            olist_pkg::S_DECODE: begin
                unique case (i_stat.action)
                    olist_pkg::ACT_INSERT: n_state = olist_pkg::S_RESP;
                    olist_pkg::ACT_DELETE: begin
                        n_state = i_stat.cnt_zero ? olist_pkg::S_RESP
                                                  : olist_pkg::S_DEL_SCAN;
                    end
                    olist_pkg::ACT_WALK: begin
                        n_state = i_stat.cnt_zero ? olist_pkg::S_RESP
                                                  : olist_pkg::S_WALK;
                    end
                    default: n_state = olist_pkg::S_IDLE;
                endcase
            end
            olist_pkg::S_DEL_SCAN: begin
                if (i_stat.idx_last) begin
                    n_state = olist_pkg::S_RESP;
                end
            end
            olist_pkg::S_WALK: begin
                if (i_stat.out_free && i_stat.idx_last) begin
                    n_state = olist_pkg::S_IDLE;
                end
            end
            olist_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = olist_pkg::S_IDLE;
                end
            end
            default: n_state = olist_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = olist_pkg::ST_OK;
        o_req_ready  = 1'b0;
        unique case (r_state)
            olist_pkg::S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = i_req_valid;
            end
            olist_pkg::S_DECODE: begin
                unique case (i_stat.action)
                    olist_pkg::ACT_INSERT: begin
                        o_cmd.set_status = 1'b1;
                        if (i_stat.cnt_full) begin
                            o_cmd.status = olist_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_insert = 1'b1;
                            o_cmd.cnt_inc   = 1'b1;
                        end
                    end
                    olist_pkg::ACT_DELETE: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = olist_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                        end
                    end
                    olist_pkg::ACT_WALK: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = olist_pkg::ST_EMPTY;
                            o_cmd.clr_value  = 1'b1;
                        end else begin
                            o_cmd.rd_start = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            olist_pkg::S_DEL_SCAN: begin
                // once the match is passed, each entry moves down one slot
                o_cmd.wr_shift  = i_stat.found;
                o_cmd.set_found = i_stat.match;
                if (i_stat.idx_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = hit ? olist_pkg::ST_OK : olist_pkg::ST_NOT_FOUND;
                    o_cmd.cnt_dec    = hit;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            olist_pkg::S_WALK: begin
                if (i_stat.out_free) begin
                    o_cmd.out_walk = 1'b1;
                    o_cmd.advance  = ~i_stat.idx_last;
                end
            end
            olist_pkg::S_RESP: begin
                o_cmd.out_resp = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/ordered_list_insert_delete_walk_top.sv =====
// Top level of the ordered list block: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Holds up to CAPACITY signed 32-bit values in order, in a store with one
// write and one registered read per cycle. A request is taken only when the
// previous one has finished; its results leave through an output register, so
// a waiting result does not block the next request. Delete reads one entry per
// cycle, with search and compaction in a single pass; walk sends one result
// per entry and waits while the output is stalled. The store read port sets
// the pace of delete and walk.

module ordered_list_insert_delete_walk_top #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] item
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    olist_pkg::t_cmd  cmd;
    olist_pkg::t_stat stat;

    olist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    olist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_item   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule
